>>> src/assert_macros.svh
// Assertion helpers for checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> src/lspb_pkg.sv
package lspb_pkg;
  localparam int unsigned BufferBytes = 256;
  localparam int unsigned AngleBins   = 360;
  localparam int unsigned FullTurn    = AngleBins * 64;
  localparam int unsigned MaxSamples  = (BufferBytes - 11) / 3;
  localparam int unsigned SlotW       = $clog2(MaxSamples);
  localparam logic [13:0] DistMax     = 14'd16383;
  localparam logic signed [17:0] FullTurnS = 18'(FullTurn);

  localparam logic CfgHeaderLow  = 1'b0;
  localparam logic CfgHeaderHigh = 1'b1;

  localparam logic [1:0] KindOk    = 2'd0;
  localparam logic [1:0] KindCsErr = 2'd1;
  localparam logic [1:0] KindRead  = 2'd2;

  // Work passed from the byte front end to the packet back end.
  typedef struct packed {
    logic        is_read;
    logic [8:0]  bin;
    logic [6:0]  count;
    logic [15:0] fsa;
    logic [15:0] lsa;
    logic        cs_bad;
  } job_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [6:0]  count;
    logic [14:0] start_a;
    logic [14:0] end_a;
    logic [13:0] map_dist;
  } res_t;

  function automatic logic [13:0] conv_dist(input logic [15:0] raw);
    logic [13:0] d;
    d = {raw[15:8], 6'd0} | {8'd0, raw[7:2]};
    return d;
  endfunction
endpackage

>>> src/lidar_scan_packet_binner.sv
// Lidar packet binner. Bytes (action 0) and map reads (action 1) enter a
// queue-style port at one per cycle until the two-entry job queue fills
// (the job the back end works on plus one waiting). After reset the back end
// clears the distance map; transactions queue meanwhile. Sample bytes of a
// packet stall while the previous packet is still being binned. A map read
// passes through RdWait and RdData after the back end picks it up, then Emit.
// A good packet steps each sample through Prep, Mul, the bit-serial angle
// divider (Div), Fetch and Store before Emit; bad checksums go straight from
// pickup to Emit, which waits until the previous result is popped.
module lidar_scan_packet_binner (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        push,
  output logic        full,
  input  logic        action_i,
  input  logic [7:0]  rx_byte_i,
  input  logic [8:0]  bin_index_i,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  kind_o,
  output logic [6:0]  sample_count_o,
  output logic [14:0] first_angle_o,
  output logic [14:0] last_angle_o,
  output logic [13:0] distance_o
);
  logic [7:0] hl_q, hh_q;
  logic jpush, jfull, jempty, jpop, sw_we, pkt_done;
  logic [lspb_pkg::SlotW-1:0] sw_addr, sr_addr;
  logic [15:0] sw_data, sr_data;
  lspb_pkg::job_t jin, jout;
  lspb_pkg::res_t res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hl_q <= 8'hAA;
      hh_q <= 8'h55;
    end else if (cfg_we_i) begin
      if (cfg_index_i == lspb_pkg::CfgHeaderLow) hl_q <= cfg_data_i;
      else hh_q <= cfg_data_i;
    end
  end

  lspb_front u_front (
    .clk_i, .rst_ni, .header_low_i(hl_q), .header_high_i(hh_q),
    .push_i(push), .action_i, .rx_byte_i, .bin_index_i, .full_o(full),
    .job_push_o(jpush), .job_o(jin), .job_full_i(jfull), .pkt_done_i(pkt_done),
    .sw_we_o(sw_we), .sw_addr_o(sw_addr), .sw_data_o(sw_data)
  );

  lspb_ram #(.Width(16), .Depth(1 << lspb_pkg::SlotW)) u_samp (
    .clk_i, .we_i(sw_we), .waddr_i(sw_addr), .wdata_i(sw_data),
    .raddr_i(sr_addr), .rdata_o(sr_data)
  );

  lspb_fifo u_fifo (
    .clk_i, .rst_ni, .push_i(jpush), .data_i(jin), .full_o(jfull),
    .empty_o(jempty), .pop_i(jpop), .data_o(jout)
  );

  lspb_back u_back (
    .clk_i, .rst_ni, .job_empty_i(jempty), .job_i(jout), .job_pop_o(jpop),
    .pkt_done_o(pkt_done), .sr_addr_o(sr_addr), .sr_data_i(sr_data),
    .empty_o(empty), .pop_i(pop), .res_o(res)
  );

  assign kind_o         = res.kind;
  assign sample_count_o = res.count;
  assign first_angle_o  = res.start_a;
  assign last_angle_o   = res.end_a;
  assign distance_o     = res.map_dist;
endmodule

>>> src/lspb_ram.sv
module lspb_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

>>> src/lspb_front.sv
// Header parser, sample capture and running checksum.
module lspb_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [7:0]          header_low_i,
  input  logic [7:0]          header_high_i,
  input  logic                push_i,
  input  logic                action_i,
  input  logic [7:0]          rx_byte_i,
  input  logic [8:0]          bin_index_i,
  output logic                full_o,
  output logic                job_push_o,
  output lspb_pkg::job_t      job_o,
  input  logic                job_full_i,
  input  logic                pkt_done_i,
  output logic                sw_we_o,
  output logic [lspb_pkg::SlotW-1:0] sw_addr_o,
  output logic [15:0]         sw_data_o
);
  typedef enum logic [1:0] {HuntLo, HuntHi, Head, Samp} st_e;

  st_e         st_q;
  logic [2:0]  hpos_q;
  logic [63:0] hf_q;
  logic [15:0] x_q;
  logic [6:0]  slot_q;
  logic [1:0]  part_q;
  logic [7:0]  ilo_q;
  logic        pkt_busy_q;

  logic        take;
  logic [15:0] x_b;
  logic [9:0]  need;

  // sample bytes wait while the back end still reads the previous packet
  assign full_o = job_full_i || (pkt_busy_q && st_q == Samp);
  assign take   = push_i && !full_o;
  assign need   = {rx_byte_i, 1'b0} + {2'd0, rx_byte_i} + 10'd10;

  always_comb begin
    x_b = x_q;
    if (part_q == 2'd0) x_b = x_q ^ {8'd0, rx_byte_i};
    else if (part_q == 2'd1) x_b = x_q ^ {8'd0, rx_byte_i};
    else x_b = x_q ^ {rx_byte_i, 8'd0};
  end

  assign sw_we_o   = take && !action_i && st_q == Samp && part_q == 2'd2;
  assign sw_addr_o = slot_q;
  assign sw_data_o = {rx_byte_i, ilo_q};

  always_comb begin
    job_push_o     = 1'b0;
    job_o          = '0;
    job_o.bin      = bin_index_i;
    job_o.count    = hf_q[14:8];
    job_o.fsa      = hf_q[31:16];
    job_o.lsa      = hf_q[47:32];
    job_o.cs_bad   = (x_b ^ {header_high_i, header_low_i}) != hf_q[63:48];
    if (take && action_i) begin
      job_push_o    = 1'b1;
      job_o.is_read = 1'b1;
    end else if (take && st_q == Samp && part_q == 2'd2 && slot_q + 7'd1 == hf_q[14:8]) begin
      job_push_o = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= HuntLo;
      hpos_q     <= '0;
      hf_q       <= '0;
      x_q        <= '0;
      slot_q     <= '0;
      part_q     <= '0;
      ilo_q      <= '0;
      pkt_busy_q <= 1'b0;
    end else begin
      if (job_push_o && !job_o.is_read) pkt_busy_q <= 1'b1;
      else if (pkt_done_i) pkt_busy_q <= 1'b0;
      if (take && !action_i) begin
        unique case (st_q)
          HuntLo: if (rx_byte_i == header_low_i) st_q <= HuntHi;
          HuntHi: begin
            if (rx_byte_i == header_high_i) begin
              st_q   <= Head;
              hpos_q <= '0;
              hf_q   <= '0;
            end
          end
          Head: begin
            if (hpos_q == 3'd1 && (rx_byte_i == 8'd0 ||
                need >= 10'(lspb_pkg::BufferBytes))) begin
              st_q <= HuntLo;
              hf_q <= '0;
            end else begin
              hf_q[hpos_q*8 +: 8] <= rx_byte_i;
              hpos_q <= hpos_q + 3'd1;
              if (hpos_q == 3'd7) begin
                st_q   <= Samp;
                slot_q <= '0;
                part_q <= '0;
                x_q    <= hf_q[15:0] ^ hf_q[31:16] ^ hf_q[47:32];
              end
            end
          end
          Samp: begin
            x_q <= x_b;
            if (part_q == 2'd1) ilo_q <= rx_byte_i;
            if (part_q == 2'd2) begin
              part_q <= '0;
              slot_q <= slot_q + 7'd1;
              if (slot_q + 7'd1 == hf_q[14:8]) st_q <= HuntLo;
            end else begin
              part_q <= part_q + 2'd1;
            end
          end
          default: st_q <= HuntLo;
        endcase
      end
    end
  end
endmodule

>>> src/lspb_fifo.sv
// Two-entry job queue between parser and back end.
module lspb_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  lspb_pkg::job_t data_i,
  output logic           full_o,
  output logic           empty_o,
  input  logic           pop_i,
  output lspb_pkg::job_t data_o
);
  lspb_pkg::job_t mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) mem_q[wp_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i && !full_o) wp_q <= ~wp_q;
      if (pop_i && !empty_o) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push_i && !full_o) - 2'(pop_i && !empty_o);
    end
  end
endmodule

>>> src/lspb_back.sv
// Map reads and packet commit: angle interpolation through a serial divider.
module lspb_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           job_empty_i,
  input  lspb_pkg::job_t job_i,
  output logic           job_pop_o,
  output logic           pkt_done_o,
  output logic [lspb_pkg::SlotW-1:0] sr_addr_o,
  input  logic [15:0]    sr_data_i,
  output logic           empty_o,
  input  logic           pop_i,
  output lspb_pkg::res_t res_o
);
  typedef enum logic [3:0] {
    Idle, RdWait, RdData, Clear, Prep, Mul, Div, Fetch, Store, Emit
  } st_e;

  st_e          st_q;
  logic         vld_q;
  lspb_pkg::res_t res_q;
  lspb_pkg::job_t job_q;
  logic [8:0]   clr_q;
  logic [13:0]  rdist_q;
  logic [6:0]   i_q;
  logic signed [16:0] span_q;
  logic [21:0]  num_q;
  logic [21:0]  quo_q;
  logic [6:0]   rem_q;
  logic [4:0]   dstep_q;
  logic         neg_q;
  logic signed [17:0] ang_q;

  logic         m_we;
  logic [8:0]   m_waddr, m_raddr;
  logic [13:0]  m_wdata, m_rdata;
  logic [6:0]   den;
  logic [7:0]   rtry;
  logic signed [17:0] qs, sa, ea;
  logic [8:0]   binv;

  lspb_ram #(.Width(14), .Depth(lspb_pkg::AngleBins)) u_map (
    .clk_i, .we_i(m_we), .waddr_i(m_waddr), .wdata_i(m_wdata),
    .raddr_i(m_raddr), .rdata_o(m_rdata)
  );

  assign den        = job_q.count - 7'd1;
  assign rtry       = {rem_q, num_q[21]};
  assign sa         = 18'($signed({2'b0, job_q.fsa[15:1]}));
  assign ea         = 18'($signed({2'b0, job_q.lsa[15:1]}));
  assign qs         = neg_q ? sa - 18'($signed({1'b0, quo_q[16:0]}))
                            : sa + 18'($signed({1'b0, quo_q[16:0]}));
  assign binv       = 9'(ang_q[17:6]);
  assign m_raddr    = job_i.bin;
  assign sr_addr_o  = i_q;
  assign job_pop_o  = st_q == Emit && (!vld_q || pop_i);
  assign pkt_done_o = job_pop_o && !job_q.is_read;
  assign empty_o    = !vld_q;
  assign res_o      = res_q;

  always_comb begin
    m_we    = 1'b0;
    m_waddr = binv;
    m_wdata = lspb_pkg::conv_dist(sr_data_i);
    if (st_q == Clear) begin
      m_we    = 1'b1;
      m_waddr = clr_q;
      m_wdata = '0;
    end else if (st_q == Store && !ang_q[17] && ang_q < lspb_pkg::FullTurnS) begin
      m_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= Clear;
      vld_q   <= 1'b0;
      res_q   <= '0;
      job_q   <= '0;
      clr_q   <= '0;
      rdist_q <= '0;
      i_q     <= '0;
      span_q  <= '0;
      num_q   <= '0;
      quo_q   <= '0;
      rem_q   <= '0;
      dstep_q <= '0;
      neg_q   <= 1'b0;
      ang_q   <= '0;
    end else begin
      if (job_pop_o) vld_q <= 1'b1;
      else if (pop_i) vld_q <= 1'b0;
      unique case (st_q)
        Clear: begin
          clr_q <= clr_q + 9'd1;
          if (clr_q == 9'(lspb_pkg::AngleBins - 1)) st_q <= Idle;
        end
        Idle: begin
          if (!job_empty_i) begin
            job_q <= job_i;
            if (job_i.is_read) st_q <= RdWait;
            else begin
              i_q  <= '0;
              st_q <= job_i.cs_bad ? Emit : Prep;
            end
          end
        end
        RdWait: st_q <= RdData;
        RdData: begin
          rdist_q <= (job_q.bin < 9'(lspb_pkg::AngleBins)) ? m_rdata : '0;
          st_q    <= Emit;
        end
        Prep: begin
          if (i_q == job_q.count) st_q <= Emit;
          else begin
            if (sa > ea) span_q <= 17'(lspb_pkg::FullTurnS - sa + ea);
            else         span_q <= 17'(ea - sa);
            st_q <= Mul;
          end
        end
        Mul: begin
          // |span*i| fits 22 bits; divide magnitude, reapply sign
          neg_q   <= span_q[16];
          num_q   <= 22'((span_q[16] ? -span_q : span_q) * $signed({1'b0, i_q}));
          quo_q   <= '0;
          rem_q   <= '0;
          dstep_q <= '0;
          st_q    <= Div;
        end
        Div: begin
          num_q <= {num_q[20:0], 1'b0};
          if (rtry >= {1'b0, den}) begin
            rem_q <= 7'(rtry - {1'b0, den});
            quo_q <= {quo_q[20:0], 1'b1};
          end else begin
            rem_q <= rtry[6:0];
            quo_q <= {quo_q[20:0], 1'b0};
          end
          dstep_q <= dstep_q + 5'd1;
          if (dstep_q == 5'd21) st_q <= Fetch;
        end
        Fetch: begin
          if (i_q + 7'd1 == job_q.count) ang_q <= ea;
          else if (i_q == 7'd0 || span_q == 17'sd0) ang_q <= sa;
          else if (qs > lspb_pkg::FullTurnS) ang_q <= qs - lspb_pkg::FullTurnS;
          else if (qs < 0) ang_q <= qs + lspb_pkg::FullTurnS;
          else ang_q <= qs;
          st_q <= Store;
        end
        Store: begin
          i_q  <= i_q + 7'd1;
          st_q <= Prep;
        end
        Emit: begin
          if (!vld_q || pop_i) begin
            if (job_q.is_read) begin
              res_q.kind     <= lspb_pkg::KindRead;
              res_q.count    <= '0;
              res_q.start_a  <= '0;
              res_q.end_a    <= '0;
              res_q.map_dist <= rdist_q;
            end else begin
              res_q.kind     <= job_q.cs_bad ? lspb_pkg::KindCsErr : lspb_pkg::KindOk;
              res_q.count    <= job_q.count;
              res_q.start_a  <= job_q.fsa[15:1];
              res_q.end_a    <= job_q.lsa[15:1];
              res_q.map_dist <= '0;
            end
            st_q <= Idle;
          end
        end
        default: st_q <= Idle;
      endcase
    end
  end

  logic unused_ok;
  assign unused_ok = ^{quo_q[21:17]};
endmodule

>>> src/lspb_checker.sv
`include "assert_macros.svh"

module lspb_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        empty,
  input logic        pop,
  input logic [1:0]  kind_o,
  input logic [6:0]  sample_count_o,
  input logic [13:0] distance_o
);
  logic rd_shown, pk_shown;

  assign rd_shown = !empty && kind_o == lspb_pkg::KindRead;
  assign pk_shown = !empty && kind_o != lspb_pkg::KindRead;

  `ASSERT_IMPL(a_kind, clk_i, rst_ni, !empty, kind_o <= lspb_pkg::KindRead)
  `ASSERT_IMPL(a_rd_cnt, clk_i, rst_ni, rd_shown, sample_count_o == 7'd0)
  `ASSERT_IMPL(a_pk_dist, clk_i, rst_ni, pk_shown, distance_o == 14'd0)
  `ASSERT_NEXT(a_hold, clk_i, rst_ni, !empty && !pop, !empty && $stable(kind_o))
endmodule

bind lidar_scan_packet_binner lspb_checker u_chk (
  .clk_i, .rst_ni, .empty, .pop, .kind_o, .sample_count_o, .distance_o
);

>>> tb/tb_top.sv
module tb_top;
  typedef struct packed {
    logic       action;
    logic [7:0] rx_byte;
    logic [8:0] bin_index;
  } lidar_item_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_index_i;
  logic [7:0]  cfg_data_i;
  logic        push;
  logic        full;
  logic        action_i;
  logic [7:0]  rx_byte_i;
  logic [8:0]  bin_index_i;
  logic        empty;
  logic        pop;
  logic [1:0]  kind_o;
  logic [6:0]  sample_count_o;
  logic [14:0] first_angle_o;
  logic [14:0] last_angle_o;
  logic [13:0] distance_o;

  lidar_scan_packet_binner u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_index_i(cfg_index_i),
    .cfg_data_i(cfg_data_i), .push(push), .full(full), .action_i(action_i),
    .rx_byte_i(rx_byte_i), .bin_index_i(bin_index_i), .empty(empty), .pop(pop),
    .kind_o(kind_o), .sample_count_o(sample_count_o), .first_angle_o(first_angle_o),
    .last_angle_o(last_angle_o), .distance_o(distance_o)
  );

  localparam logic ActByte = 1'b0;
  localparam logic ActRead = 1'b1;

  // predictor state
  logic [7:0]  hdr_lo, hdr_hi;
  int unsigned step, total, bpos;
  logic [63:0] fields;
  logic [23:0] samples [lspb_pkg::MaxSamples];
  logic [13:0] dist_map [lspb_pkg::AngleBins];

  lidar_item_t      pending_q[$];
  lspb_pkg::res_t   expected_q[$];
  int unsigned fail_cnt;
  int unsigned sent_cnt;
  bit          calm;

  function automatic logic [13:0] scale_distance(logic [15:0] raw);
    int unsigned d;
    d = (int'(raw[15:8]) << 6) | int'(raw[7:2]);
    return (d > 16383) ? 14'd16383 : d[13:0];
  endfunction

  function automatic int interp_angle(int i, int n, int sa, int ea);
    int span, q, turn;
    turn = int'(lspb_pkg::FullTurn);
    if (i + 1 == n) return ea;
    if (i == 0) return sa;
    span = (sa > ea) ? (turn - sa + ea) : (ea - sa);
    if (span == 0) return sa;
    q = sa + (span * i) / (n - 1);
    if (q > turn) q -= turn;
    else if (q < 0) q += turn;
    return q;
  endfunction

  function automatic void close_packet();
    lspb_pkg::res_t r;
    logic [15:0] x, fsa, lsa;
    int sa, ea, a;
    int unsigned n;
    n = fields[15:8];
    fsa = fields[31:16];
    lsa = fields[47:32];
    x = {hdr_hi, hdr_lo} ^ fields[15:0] ^ fsa ^ lsa;
    for (int i = 0; i < n; i++) x ^= {8'd0, samples[i][7:0]} ^ samples[i][23:8];
    sa = fsa >> 1;
    ea = lsa >> 1;
    r = '0;
    r.count = 7'(n);
    r.start_a = fsa[15:1];
    r.end_a = lsa[15:1];
    if (x != fields[63:48]) begin
      r.kind = lspb_pkg::KindCsErr;
    end else begin
      r.kind = lspb_pkg::KindOk;
      for (int i = 0; i < n; i++) begin
        a = interp_angle(i, n, sa, ea);
        if (a >= 0 && a / 64 < lspb_pkg::AngleBins)
          dist_map[a / 64] = scale_distance(samples[i][23:8]);
      end
    end
    expected_q.push_back(r);
  endfunction

  function automatic void predict_item(lidar_item_t it);
    lspb_pkg::res_t r;
    if (it.action == ActRead) begin
      r = '0;
      r.kind = lspb_pkg::KindRead;
      r.map_dist = (it.bin_index < lspb_pkg::AngleBins) ? dist_map[it.bin_index] : '0;
      expected_q.push_back(r);
      return;
    end
    if (step == 0) begin
      if (it.rx_byte == hdr_lo) step = 1;
    end else if (step == 1) begin
      if (it.rx_byte == hdr_hi) begin
        step = 2;
        fields = '0;
      end
    end else if (step <= 9) begin
      fields |= 64'(it.rx_byte) << ((step - 2) * 8);
      if (step == 3) begin
        total = it.rx_byte;
        bpos = 0;
        if (total == 0 || total * 3 + 10 >= lspb_pkg::BufferBytes) begin
          step = 0;
          return;
        end
      end
      step++;
    end else begin
      if (bpos % 3 == 0) samples[bpos / 3] = '0;
      samples[bpos / 3] |= 24'(it.rx_byte) << ((bpos % 3) * 8);
      bpos++;
      if (bpos == total * 3) begin
        close_packet();
        step = 0;
        bpos = 0;
      end
    end
  endfunction

  function automatic void add_byte(logic [7:0] b);
    lidar_item_t it;
    it.action = ActByte;
    it.rx_byte = b;
    it.bin_index = 9'($urandom);
    pending_q.push_back(it);
  endfunction

  function automatic void add_read(logic [8:0] b);
    lidar_item_t it;
    it.action = ActRead;
    it.rx_byte = 8'($urandom);
    it.bin_index = b;
    pending_q.push_back(it);
  endfunction

  // Builds one packet; bad_cs flips one checksum bit
  function automatic void add_packet(int n, int sa16, int ea16, bit bad_cs, bit rnd_dist);
    logic [15:0] x, fsa, lsa, cs;
    logic [7:0]  ty;
    logic [23:0] s [$];
    fsa = 16'(sa16);
    lsa = 16'(ea16);
    ty = 8'($urandom);
    x = {hdr_hi, hdr_lo} ^ {8'(n), ty} ^ fsa ^ lsa;
    for (int i = 0; i < n; i++) begin
      s.push_back(rnd_dist ? 24'($urandom) : {16'hFFFF, 8'($urandom)});
      x ^= {8'd0, s[i][7:0]} ^ s[i][23:8];
    end
    cs = bad_cs ? (x ^ 16'(1 << $urandom_range(15, 0))) : x;
    add_byte(hdr_lo);
    if ($urandom_range(3, 0) == 0) add_byte(hdr_lo ^ 8'h01 ^ (hdr_hi ^ hdr_lo));
    add_byte(hdr_hi);
    add_byte(ty);
    add_byte(8'(n));
    add_byte(fsa[7:0]);
    add_byte(fsa[15:8]);
    add_byte(lsa[7:0]);
    add_byte(lsa[15:8]);
    add_byte(cs[7:0]);
    add_byte(cs[15:8]);
    foreach (s[i]) begin
      add_byte(s[i][7:0]);
      add_byte(s[i][15:8]);
      add_byte(s[i][23:16]);
    end
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #8000000;
    $display("lidar_scan_packet_binner verification failed");
    $finish;
  end

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push <= 1'b0;
      action_i <= 1'b0;
      rx_byte_i <= '0;
      bin_index_i <= '0;
    end else begin
      if (push && !full) begin
        predict_item({action_i, rx_byte_i, bin_index_i});
        sent_cnt++;
      end
      if (!(push && full)) begin
        if (pending_q.size() > 0 && (calm || $urandom_range(99, 0) >= 24)) begin
          {action_i, rx_byte_i, bin_index_i} <= pending_q.pop_front();
          push <= 1'b1;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    lspb_pkg::res_t want;
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_q.size() == 0) begin
          $error("unexpected transaction kind=%0d", kind_o);
          fail_cnt++;
        end else begin
          want = expected_q.pop_front();
          if (kind_o !== want.kind) begin
            $error("kind exp %0d got %0d", want.kind, kind_o); fail_cnt++;
          end
          if (sample_count_o !== want.count) begin
            $error("sample_count exp %0d got %0d", want.count, sample_count_o); fail_cnt++;
          end
          if (first_angle_o !== want.start_a) begin
            $error("first_angle exp %0d got %0d", want.start_a, first_angle_o); fail_cnt++;
          end
          if (last_angle_o !== want.end_a) begin
            $error("last_angle exp %0d got %0d", want.end_a, last_angle_o); fail_cnt++;
          end
          if (distance_o !== want.map_dist) begin
            $error("distance exp %0d got %0d", want.map_dist, distance_o); fail_cnt++;
          end
        end
      end
      pop <= calm || ($urandom_range(99, 0) >= 24);
    end
  end

  task automatic drain_and_wait();
    int unsigned guard;
    guard = 0;
    while ((pending_q.size() > 0 || push || expected_q.size() > 0) && guard < 200000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (81 * 30 + 50) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [7:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == lspb_pkg::CfgHeaderLow) hdr_lo = val;
    else hdr_hi = val;
  endtask

  initial begin
    int n, sa, ea, sel;
    cfg_we_i = 1'b0;
    cfg_index_i = 1'b0;
    cfg_data_i = '0;
    fail_cnt = 0;
    sent_cnt = 0;
    calm = 1'b0;
    hdr_lo = 8'hAA;
    hdr_hi = 8'h55;
    step = 0; total = 0; bpos = 0; fields = '0;
    foreach (dist_map[i]) dist_map[i] = '0;
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: reads of cleared map, edge packets
    add_read(9'd0);
    add_read(9'd359);
    add_read(9'd511);
    add_byte(8'h00);
    add_byte(hdr_lo);
    add_byte(8'h13);              // junk between header bytes
    add_byte(hdr_hi);
    add_byte(8'h01);
    add_byte(8'h00);              // zero count drops
    add_packet(1, 16'hFFFF, 16'hFFFF, 0, 1);
    add_packet(81, 16'd1000, 16'd1000, 0, 0);      // zero span, max count
    add_packet(5, 16'd46000, 16'd200, 0, 1);       // wraps past a full turn
    add_packet(4, 16'd200, 16'd46000, 0, 1);
    add_packet(3, 16'd50000, 16'd60000, 0, 1);     // bins beyond 359
    add_packet(2, 16'd10, 16'd20, 1, 1);
    add_byte(hdr_lo); add_byte(hdr_hi); add_byte(8'h00); add_byte(8'd82); // oversized
    add_read(9'd7); add_read(9'd359); add_read(9'd3);
    drain_and_wait();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          write_reg(lspb_pkg::CfgHeaderLow, 8'h00);
          write_reg(lspb_pkg::CfgHeaderHigh, 8'hFF);
        end
        1: begin
          write_reg(lspb_pkg::CfgHeaderLow, 8'hFF);
          write_reg(lspb_pkg::CfgHeaderHigh, 8'h00);
        end
        2: begin
          write_reg(lspb_pkg::CfgHeaderLow, 8'($urandom));
          write_reg(lspb_pkg::CfgHeaderHigh, 8'($urandom));
        end
        default: begin
          write_reg(lspb_pkg::CfgHeaderLow, 8'hAA);
          write_reg(lspb_pkg::CfgHeaderHigh, 8'h55);
        end
      endcase
      calm = (phase == 2);
      while (pending_q.size() < 130) begin
        sel = $urandom_range(9, 0);
        if (sel < 5) begin
          n = ($urandom_range(9, 0) == 0) ? $urandom_range(81, 1) : $urandom_range(6, 1);
          sa = $urandom_range(65535, 0);
          ea = ($urandom_range(3, 0) == 0) ? sa : $urandom_range(65535, 0);
          if ($urandom_range(1, 0)) ea = sa[15:0] + $urandom_range(1000, 0);
          add_packet(n, sa, ea, $urandom_range(5, 0) == 0, 1);
        end else if (sel < 8) begin
          add_read(9'(($urandom_range(9, 0) == 0) ? $urandom_range(511, 0)
                                                  : $urandom_range(359, 0)));
        end else if (sel == 8) begin
          add_byte(hdr_lo); add_byte(hdr_hi); add_byte(8'($urandom));
          add_byte($urandom_range(1, 0) ? 8'd0 : 8'($urandom_range(255, 82)));
        end else begin
          add_byte(8'($urandom));
        end
      end
      drain_and_wait();
    end

    if (fail_cnt == 0 && expected_q.size() == 0) begin
      $display("lidar_scan_packet_binner verification clean");
    end else begin
      $display("lidar_scan_packet_binner verification failed");
    end
    $finish;
  end
endmodule

>>> sim.f
+incdir+src
src/lspb_pkg.sv
src/lspb_ram.sv
src/lspb_front.sv
src/lspb_fifo.sv
src/lspb_back.sv
src/lidar_scan_packet_binner.sv
src/lspb_checker.sv
tb/tb_top.sv
